// ===== design/frame_header_length_xor_checker_top_defines.svh =====
// ---------------------------------------------------------------------------
// Frame checker assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef FRAME_HEADER_LENGTH_XOR_CHECKER_TOP_DEFINES_SVH
`define FRAME_HEADER_LENGTH_XOR_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FHLX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame checker assertion failed");
`define FHLX_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("frame checker forbidden condition");
`else
`define FHLX_ASSERT(label, clk, rst_n, prop)
`define FHLX_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== design/fhlx_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame checker package
// Request types, frame layout constants and fault codes.
// ---------------------------------------------------------------------------
package fhlx_pkg;

    localparam int INDEX_W = 16;
    localparam int FAULT_W = 3;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [INDEX_W-1:0] POS_SYNC_LAST = 16'd1;
    localparam logic [INDEX_W-1:0] POS_LEN_LO = 16'd6;
    localparam logic [INDEX_W-1:0] POS_LEN_HI = 16'd7;
    localparam logic [INDEX_W-1:0] CHECK_POS = 16'd8;
    localparam logic [INDEX_W-1:0] DATA_START = 16'd9;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_SYNC = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_LENGTH = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_CHECK = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_SHORT = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic               frame_ok;
        logic [FAULT_W-1:0] fault_code;
    } verdict_item_t;

endpackage

// ===== design/fhlx_in_stage.sv =====
// ---------------------------------------------------------------------------
// Frame checker input stage
// Input register that holds one byte request until the core takes it.
// ---------------------------------------------------------------------------
module fhlx_in_stage
    import fhlx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    input  logic       take,
    output logic       held_valid,
    output byte_item_t held_item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       accept;

    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= byte_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== design/fhlx_check_core.sv =====
// ---------------------------------------------------------------------------
// Frame checker core
// Per-frame state, byte absorption and end-of-frame verdict.
// ---------------------------------------------------------------------------
`include "frame_header_length_xor_checker_top_defines.svh"

module fhlx_check_core
    import fhlx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  byte_item_t    item,
    output verdict_item_t verdict
);

    logic [INDEX_W-1:0] byte_index_reg;
    logic [INDEX_W-1:0] byte_index_next;
    logic               index_overflow_reg;
    logic               index_overflow_next;
    logic               sync_bad_reg;
    logic               sync_bad_next;
    logic [15:0]        length_field_reg;
    logic [15:0]        length_field_next;
    logic [7:0]         stored_check_reg;
    logic [7:0]         stored_check_next;
    logic [7:0]         running_xor_reg;
    logic [7:0]         running_xor_next;

    logic [15:0]        len_abs;
    logic [7:0]         check_abs;
    logic [7:0]         xor_abs;
    logic               sync_abs;
    logic               absorb;
    logic [FAULT_W-1:0] code;

    assign absorb = !index_overflow_reg;

    always_comb
    begin
        sync_abs  = sync_bad_reg;
        len_abs   = length_field_reg;
        check_abs = stored_check_reg;
        xor_abs   = running_xor_reg;
        if (absorb)
        begin
            if (byte_index_reg <= POS_SYNC_LAST)
            begin
                sync_abs = sync_bad_reg || (item.data_byte != SYNC_BYTE);
            end
            else if (byte_index_reg == POS_LEN_LO)
            begin
                len_abs = {length_field_reg[15:8], item.data_byte};
            end
            else if (byte_index_reg == POS_LEN_HI)
            begin
                len_abs = {item.data_byte, length_field_reg[7:0]};
            end
            else if (byte_index_reg == CHECK_POS)
            begin
                check_abs = item.data_byte;
            end
            else if (byte_index_reg >= DATA_START)
            begin
                xor_abs = running_xor_reg ^ item.data_byte;
            end
        end
    end

    always_comb
    begin
        if (!index_overflow_reg && byte_index_reg < DATA_START)
        begin
            code = FAULT_SHORT;
        end
        else if (sync_abs)
        begin
            code = FAULT_SYNC;
        end
        else if (index_overflow_reg || byte_index_reg == INDEX_MAX)
        begin
            code = FAULT_LENGTH;
        end
        else if (len_abs != byte_index_reg + 16'd1)
        begin
            code = FAULT_LENGTH;
        end
        else if (xor_abs != check_abs)
        begin
            code = FAULT_CHECK;
        end
        else
        begin
            code = FAULT_NONE;
        end
    end

    assign verdict.fault_code = code;
    assign verdict.frame_ok   = (code == FAULT_NONE);

    always_comb
    begin
        byte_index_next     = byte_index_reg;
        index_overflow_next = index_overflow_reg;
        sync_bad_next       = sync_bad_reg;
        length_field_next   = length_field_reg;
        stored_check_next   = stored_check_reg;
        running_xor_next    = running_xor_reg;
        if (fire)
        begin
            if (item.last_byte)
            begin
                byte_index_next     = '0;
                index_overflow_next = 1'b0;
                sync_bad_next       = 1'b0;
                length_field_next   = '0;
                stored_check_next   = '0;
                running_xor_next    = '0;
            end
            else
            begin
                sync_bad_next     = sync_abs;
                length_field_next = len_abs;
                stored_check_next = check_abs;
                running_xor_next  = xor_abs;
                if (!index_overflow_reg)
                begin
                    if (byte_index_reg == INDEX_MAX)
                    begin
                        index_overflow_next = 1'b1;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg     <= '0;
            index_overflow_reg <= 1'b0;
            sync_bad_reg       <= 1'b0;
            length_field_reg   <= '0;
            stored_check_reg   <= '0;
            running_xor_reg    <= '0;
        end
        else
        begin
            byte_index_reg     <= byte_index_next;
            index_overflow_reg <= index_overflow_next;
            sync_bad_reg       <= sync_bad_next;
            length_field_reg   <= length_field_next;
            stored_check_reg   <= stored_check_next;
            running_xor_reg    <= running_xor_next;
        end
    end

    `FHLX_ASSERT(a_clear_after_last, clk, rst_n, (fire && item.last_byte) |=> (byte_index_reg == '0 && !index_overflow_reg && running_xor_reg == '0))
    `FHLX_ASSERT(a_overflow_saturated, clk, rst_n, index_overflow_reg |-> (byte_index_reg == INDEX_MAX))
    `FHLX_ASSERT_NEVER(a_short_has_data, clk, rst_n, (!index_overflow_reg && byte_index_reg < DATA_START && running_xor_reg != '0))

endmodule

// ===== design/fhlx_out_stage.sv =====
// ---------------------------------------------------------------------------
// Frame checker output stage
// Result register that holds a verdict request until the receiver takes it.
// ---------------------------------------------------------------------------
module fhlx_out_stage
    import fhlx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  verdict_item_t load_item,
    output logic          free,
    output logic          verdict_valid,
    input  logic          verdict_stall,
    output verdict_item_t verdict_item
);

    logic          valid_reg;
    logic          valid_next;
    verdict_item_t item_reg;

    assign free = !valid_reg || !verdict_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!verdict_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign verdict_valid = valid_reg;
    assign verdict_item  = item_reg;

endmodule

// ===== design/frame_header_length_xor_checker_top.sv =====
// ---------------------------------------------------------------------------
// Frame header, length and XOR checker
// Checks sync bytes, length field and XOR checksum of a byte-serial frame.
// ---------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_item) carries one frame
//   byte per request, byte 0 first, with last_byte set on the final byte.
//   The verdict channel (verdict_valid, verdict_stall, verdict_item) gives
//   one request per frame: frame_ok and the first failing fault_code.
//   Throughput is one byte per cycle unless a stalled verdict holds the
//   last byte. A byte waits in the input register until the core takes
//   it, and a last byte's verdict is registered as that byte is taken.
//   The last byte waits in the input register only while a previous
//   verdict is still stalled in the result register; other bytes pass.
//   While verdict_stall is high the verdict holds; byte_stall rises once
//   a final byte reaches the input register behind it.
//   Reset clears both registers' valid flags and all per-frame state;
//   the first byte after reset is byte 0 of a frame.
// ---------------------------------------------------------------------------
module frame_header_length_xor_checker_top
    import fhlx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  byte_item_t    byte_item,
    output logic          verdict_valid,
    input  logic          verdict_stall,
    output verdict_item_t verdict_item
);

    logic          held_valid;
    byte_item_t    held_item;
    logic          out_free;
    logic          take;
    verdict_item_t core_verdict;

    assign take = held_valid && (!held_item.last_byte || out_free);

    fhlx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    fhlx_check_core u_check_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (take),
        .item    (held_item),
        .verdict (core_verdict)
    );

    fhlx_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take && held_item.last_byte),
        .load_item     (core_verdict),
        .free          (out_free),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict_item  (verdict_item)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frame checker testbench
// Sends byte-serial frames through the checker and compares each verdict with
// a cycle-free model of sync, length and XOR checking, or with the expected
// code of a typed table row. A table of frames covers short, malformed and
// maximum-length frames, then random frames run under three idling mixes, with
// one long verdict hold-off that backs up the byte channel.
// ---------------------------------------------------------------------------
module testbench;
    import fhlx_pkg::*;

    localparam int unsigned FLAW_NONE   = 0;
    localparam int unsigned FLAW_SYNC0  = 1;
    localparam int unsigned FLAW_SYNC1  = 2;
    localparam int unsigned FLAW_LENGTH = 4;
    localparam int unsigned FLAW_CHECK  = 8;
    localparam int unsigned FLAW_NOISE  = 16;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned PLAN_ROWS   = 19;

    typedef struct packed {
        logic [16:0]        len;
        logic [4:0]         flaws;
        logic               fixed_fill;
        logic [7:0]         fill;
        logic               typed;
        logic [FAULT_W-1:0] code;
    } frame_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          byte_valid = 1'b0;
    logic          byte_stall;
    byte_item_t    byte_item = '0;
    logic          verdict_valid;
    logic          verdict_stall = 1'b0;
    verdict_item_t verdict_item;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    bit              pressure_go = 1'b0;
    logic            hold_verdicts = 1'b0;
    int unsigned     mismatch_count = 0;
    verdict_item_t   verdicts_due[$];
    logic [7:0]      frame_bytes[$];
    frame_row_t      plan [PLAN_ROWS];

    logic [INDEX_W-1:0] pos = '0;
    logic               pos_saturated = 1'b0;
    logic               sync_fail = 1'b0;
    logic [15:0]        len_word = '0;
    logic [7:0]         check_byte = '0;
    logic [7:0]         xor_acc = '0;

    frame_header_length_xor_checker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_item     (byte_item),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict_item  (verdict_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("%0t ns: verdict mismatch: %s", $time, what);
    endtask

    function automatic bit frame_absorb(input byte_item_t it, output verdict_item_t v);
        logic [FAULT_W-1:0] code;
        v = '0;
        if (!pos_saturated)
        begin
            if (pos == '0 || pos == POS_SYNC_LAST)
            begin
                if (it.data_byte != SYNC_BYTE)
                    sync_fail = 1'b1;
            end
            else if (pos == POS_LEN_LO)
                len_word[7:0] = it.data_byte;
            else if (pos == POS_LEN_HI)
                len_word[15:8] = it.data_byte;
            else if (pos == CHECK_POS)
                check_byte = it.data_byte;
            else if (pos >= DATA_START)
                xor_acc ^= it.data_byte;
        end
        if (it.last_byte)
        begin
            if (!pos_saturated && pos < DATA_START)
                code = FAULT_SHORT;
            else if (sync_fail)
                code = FAULT_SYNC;
            else if (pos_saturated || pos == INDEX_MAX)
                code = FAULT_LENGTH;
            else if (len_word != pos + 16'd1)
                code = FAULT_LENGTH;
            else if (xor_acc != check_byte)
                code = FAULT_CHECK;
            else
                code = FAULT_NONE;
            v.frame_ok = (code == FAULT_NONE);
            v.fault_code = code;
            pos = '0;
            pos_saturated = 1'b0;
            sync_fail = 1'b0;
            len_word = '0;
            check_byte = '0;
            xor_acc = '0;
            return 1'b1;
        end
        if (!pos_saturated)
        begin
            if (pos == INDEX_MAX)
                pos_saturated = 1'b1;
            else
                pos = pos + 16'd1;
        end
        return 1'b0;
    endfunction

    function automatic frame_row_t plan_row(input int unsigned len, input int unsigned flaws,
                                            input bit fixed_fill, input logic [7:0] fill,
                                            input bit typed, input logic [FAULT_W-1:0] code);
        frame_row_t r;
        r.len = 17'(len);
        r.flaws = 5'(flaws);
        r.fixed_fill = fixed_fill;
        r.fill = fill;
        r.typed = typed;
        r.code = code;
        return r;
    endfunction

    function automatic void build_frame(input frame_row_t r);
        logic [7:0]  sum;
        logic [15:0] field;
        frame_bytes.delete();
        sum = '0;
        field = r.len[15:0];
        for (int unsigned i = 0; i < r.len; i++)
            frame_bytes.push_back(r.fixed_fill ? r.fill : 8'($urandom_range(255)));
        if ((r.flaws & FLAW_NOISE) != 0)
            return;
        if ((r.flaws & FLAW_LENGTH) != 0)
            field ^= 16'd1 << $urandom_range(15);
        frame_bytes[0] = ((r.flaws & FLAW_SYNC0) != 0) ?
                         SYNC_BYTE ^ 8'($urandom_range(1, 255)) : SYNC_BYTE;
        if (r.len > POS_SYNC_LAST)
            frame_bytes[POS_SYNC_LAST] = ((r.flaws & FLAW_SYNC1) != 0) ?
                                         SYNC_BYTE ^ 8'($urandom_range(1, 255)) : SYNC_BYTE;
        if (r.len > POS_LEN_LO)
            frame_bytes[POS_LEN_LO] = field[7:0];
        if (r.len > POS_LEN_HI)
            frame_bytes[POS_LEN_HI] = field[15:8];
        for (int unsigned i = DATA_START; i < r.len; i++)
            sum ^= frame_bytes[i];
        if ((r.flaws & FLAW_CHECK) != 0)
            sum ^= 8'($urandom_range(1, 255));
        if (r.len > CHECK_POS)
            frame_bytes[CHECK_POS] = sum;
    endfunction

    task automatic send_byte(input byte_item_t it, output bit ends, output verdict_item_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        ends = frame_absorb(it, v);
    endtask

    task automatic send_frame(input frame_row_t r);
        bit            ends;
        verdict_item_t v;
        build_frame(r);
        for (int unsigned i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte({frame_bytes[i], i == frame_bytes.size() - 1}, ends, v);
            if (ends)
            begin
                if (r.typed)
                begin
                    v.frame_ok = (r.code == FAULT_NONE);
                    v.fault_code = r.code;
                end
                verdicts_due.push_back(v);
            end
        end
    endtask

    always @(posedge clk)
        verdict_stall <= hold_verdicts || ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin : watch_verdicts
        verdict_item_t want;
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("verdict with no frame pending");
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict_item.frame_ok !== want.frame_ok)
                    report_mismatch($sformatf("frame_ok %b, want %b",
                                              verdict_item.frame_ok, want.frame_ok));
                if (verdict_item.fault_code !== want.fault_code)
                    report_mismatch($sformatf("fault_code %0d, want %0d",
                                              verdict_item.fault_code, want.fault_code));
            end
        end
    end

    // back up the byte channel behind a held verdict
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_verdicts <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_verdicts <= 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        frame_row_t  rnd;
        int unsigned pick;
        int unsigned sent;
        int unsigned frames;

        plan = '{
            plan_row(10,    FLAW_NONE,   0, 8'h00, 1, FAULT_NONE),
            plan_row(1,     FLAW_NONE,   0, 8'h00, 1, FAULT_SHORT),
            plan_row(9,     FLAW_NONE,   0, 8'h00, 1, FAULT_SHORT),
            plan_row(5,     FLAW_SYNC0,  0, 8'h00, 1, FAULT_SHORT),
            plan_row(10,    FLAW_NONE,   1, 8'h00, 1, FAULT_NONE),
            plan_row(40,    FLAW_NONE,   1, 8'hFF, 1, FAULT_NONE),
            plan_row(12,    FLAW_SYNC0,  0, 8'h00, 1, FAULT_SYNC),
            plan_row(12,    FLAW_SYNC1,  0, 8'h00, 1, FAULT_SYNC),
            plan_row(12,    FLAW_SYNC1 | FLAW_LENGTH | FLAW_CHECK, 0, 8'h00, 1, FAULT_SYNC),
            plan_row(12,    FLAW_LENGTH, 0, 8'h00, 1, FAULT_LENGTH),
            plan_row(12,    FLAW_LENGTH | FLAW_CHECK, 0, 8'h00, 1, FAULT_LENGTH),
            plan_row(12,    FLAW_CHECK,  0, 8'h00, 1, FAULT_CHECK),
            plan_row(20,    FLAW_NONE,   0, 8'h00, 0, FAULT_NONE),
            plan_row(33,    FLAW_NOISE,  0, 8'h00, 0, FAULT_NONE),
            plan_row(65535, FLAW_NONE,   1, 8'hFF, 1, FAULT_NONE),
            plan_row(65536, FLAW_NONE,   0, 8'h00, 1, FAULT_LENGTH),
            plan_row(65537, FLAW_NONE,   0, 8'h00, 1, FAULT_LENGTH),
            plan_row(65538, FLAW_SYNC0,  0, 8'h00, 1, FAULT_SYNC),
            plan_row(11,    FLAW_NONE,   0, 8'h00, 0, FAULT_NONE)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 11;
                    recv_idle_pct <= 69;
                end
                1:
                begin
                    send_idle_pct <= 69;
                    recv_idle_pct <= 11;
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    pressure_go = 1'b1;
                end
            endcase
            if (phase == 0)
                foreach (plan[i])
                    send_frame(plan[i]);
            sent = 0;
            frames = 0;
            while (frames < 12 || sent < 150)
            begin
                rnd = '0;
                pick = $urandom_range(99);
                rnd.len = 17'((pick < 10) ? $urandom_range(1, 9) :
                              (pick < 80) ? $urandom_range(10, 16) : $urandom_range(17, 64));
                pick = $urandom_range(99);
                rnd.flaws = 5'((pick < 60) ? FLAW_NONE :
                               (pick < 68) ? FLAW_SYNC0 :
                               (pick < 74) ? FLAW_SYNC1 :
                               (pick < 82) ? FLAW_LENGTH :
                               (pick < 90) ? FLAW_CHECK :
                               (pick < 95) ? $urandom_range(1, 15) : FLAW_NOISE);
                send_frame(rnd);
                sent += rnd.len;
                frames++;
            end
        end

        byte_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
